FILE: sv/pip_pkg.sv
// Shared types, constants and codes for the point-in-polygon core.
`timescale 1ns / 1ps
`default_nettype none
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;
  localparam int MIN_VERTICES     = 3;

  localparam int VIDX_W      = 6;
  localparam int VCNT_W      = 7;
  localparam int OUT_TDATA_W = 8;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register index, taken from the word address bit of paddr.
  localparam logic CFG_VCOUNT_IDX = 1'b0;

  // Input transaction kinds carried on in_tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLOSE,
    ST_DRAIN,
    ST_DONE
  } pip_state_t;

  typedef struct packed {
    logic wr_vertex;
    logic load_point;
    logic rd_en;
    logic rd_first;
    logic close_edge;
    logic load_result;
    logic too_few;
  } pip_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } pip_status_t;

endpackage
`default_nettype wire

FILE: sv/point_in_polygon_test_core.sv
// Top level of the point-in-polygon core: ports, configuration register, wiring.
// Vertex write transactions are taken back to back, one per cycle, and give no result.
// A query reads the n vertices in use one per cycle, adds the closing edge and drains a
// three-stage multiply and compare pipeline; its result is registered once any earlier
// result has been taken, and input reopens in the same cycle that result becomes valid.
// With fewer than three vertices a query skips the walk and goes straight to its result.
// Synchronous active-low reset clears control state and vertex_count, not the vertex table.
`timescale 1ns / 1ps
`default_nettype none
module point_in_polygon_test_core #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF,
  localparam int IN_TDATA_W  = ((pip_pkg::VIDX_W + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata: vertex_index, coord_x, coord_y
  input  wire logic [IN_TDATA_W-1:0]         in_tdata,
  // in_tuser: command
  input  wire logic                          in_tuser,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // out_tdata: inside_res
  output logic [pip_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: too_few_vertices
  output logic                               out_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [pip_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [pip_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [pip_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);
  import pip_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic [VCNT_W-1:0]      vertex_count_r;
  logic                   cfg_sel_vcount;
  logic [CNT_W-1:0]       n_use;
  pip_cmd_t               cmd;
  pip_status_t            status;
  logic [AW-1:0]          rd_addr;
  logic [VIDX_W-1:0]      in_vidx;
  logic signed [COORD_BITS-1:0] in_x, in_y;
  logic                   out_inside;

  assign cfg_pready     = 1'b1;
  assign cfg_sel_vcount = (cfg_paddr[CFG_AW-1] == CFG_VCOUNT_IDX);
  assign cfg_prdata     = cfg_sel_vcount ? CFG_DW'(vertex_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_vcount) begin
      vertex_count_r <= cfg_pwdata[VCNT_W-1:0];
    end
  end

  assign n_use = (32'(vertex_count_r) > 32'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                           : CNT_W'(vertex_count_r);

  assign in_vidx = in_tdata[VIDX_W-1:0];
  assign in_x    = in_tdata[VIDX_W +: COORD_BITS];
  assign in_y    = in_tdata[VIDX_W + COORD_BITS +: COORD_BITS];

  pip_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .CNT_W        (CNT_W),
    .AW           (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .n_use     (n_use),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  pip_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS),
    .AW           (AW)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_idx     (in_vidx),
    .coord_x    (in_x),
    .coord_y    (in_y),
    .status     (status),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_inside (out_inside),
    .out_few    (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(out_inside);

endmodule
`default_nettype wire

FILE: sv/pip_ctrl.sv
// Sequencer that walks the vertex table for each query and hands off the result.
`timescale 1ns / 1ps
`default_nettype none
module pip_ctrl #(
  parameter int MAX_VERTICES = 64,
  parameter int CNT_W        = 7,
  parameter int AW           = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic                 in_kind,
  input  wire logic [CNT_W-1:0]     n_use,
  input  wire pip_pkg::pip_status_t status,
  output pip_pkg::pip_cmd_t         cmd,
  output logic [AW-1:0]             rd_addr
);
  import pip_pkg::*;

  pip_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             too_few_r, too_few_nxt;
  logic             accept;
  logic             few;

  assign accept = in_tvalid && in_tready;
  assign few    = (32'(n_use) < 32'(MIN_VERTICES));

  always_comb begin
    state_nxt   = state_r;
    rd_idx_nxt  = rd_idx_r;
    n_nxt       = n_r;
    too_few_nxt = too_few_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_kind == CMD_QUERY) begin
          too_few_nxt = few;
          n_nxt       = n_use;
          rd_idx_nxt  = '0;
          state_nxt   = few ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        rd_idx_nxt = rd_idx_r + CNT_W'(1);
        if (rd_idx_r == n_r - CNT_W'(1)) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_CLOSE: state_nxt = ST_DRAIN;
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // In idle the input is always ready, so tvalid alone marks a transaction.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    rd_addr   = rd_idx_r[AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        in_tready      = 1'b1;
        cmd.wr_vertex  = in_tvalid && in_kind == CMD_WRITE;
        cmd.load_point = in_tvalid && in_kind == CMD_QUERY;
      end
      ST_WALK: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (rd_idx_r == '0);
      end
      ST_CLOSE: cmd.close_edge = 1'b1;
      ST_DRAIN: cmd = '0;
      ST_DONE: begin
        cmd.load_result = !status.out_busy;
        cmd.too_few     = too_few_r;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_idx_r  <= '0;
      n_r       <= '0;
      too_few_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_idx_r  <= rd_idx_nxt;
      n_r       <= n_nxt;
      too_few_r <= too_few_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/pip_datapath.sv
// Vertex table, edge crossing pipeline, parity counter and result register.
`timescale 1ns / 1ps
`default_nettype none
module pip_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16,
  parameter int AW           = 6
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pip_pkg::pip_cmd_t            cmd,
  input  wire logic [AW-1:0]                rd_addr,
  input  wire logic [pip_pkg::VIDX_W-1:0]   wr_idx,
  input  wire logic signed [COORD_BITS-1:0] coord_x,
  input  wire logic signed [COORD_BITS-1:0] coord_y,
  output pip_pkg::pip_status_t              status,
  input  wire logic                         out_tready,
  output logic                              out_tvalid,
  output logic                              out_inside,
  output logic                              out_few
);
  import pip_pkg::*;

  localparam int W = COORD_BITS;
  localparam int E = COORD_BITS + 1;
  localparam int P = 2 * E;

  logic [2*W-1:0] mem [MAX_VERTICES];
  logic [2*W-1:0] mem_q_r;

  logic signed [W-1:0] px_r, py_r;
  logic signed [W-1:0] v0x_r, v0y_r;
  logic signed [W-1:0] xi_r, yi_r;
  logic signed [W-1:0] xj, yj;

  logic s0_vld_r, s0_first_r, s0_close_r;
  logic s1_vld_r, s2_vld_r;
  logic edge_vld, straddle;

  logic signed [E-1:0] a_r, c_r, d_r, dy_r;
  logic signed [P-1:0] p1_r, p2_r;
  logic                s2_dyneg_r;
  logic signed [P:0]   diff;
  logic                edge_hit;
  logic                parity_r;

  logic out_valid_r, out_inside_r, out_few_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_vertex && (32'(wr_idx) < 32'(MAX_VERTICES))) begin
      mem[AW'(wr_idx)] <= {coord_y, coord_x};
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // The closing edge runs from the last vertex back to vertex zero.
  assign xj = s0_close_r ? v0x_r : mem_q_r[W-1:0];
  assign yj = s0_close_r ? v0y_r : mem_q_r[2*W-1:W];

  assign edge_vld = s0_vld_r && !s0_first_r;
  assign straddle = ((yi_r <= py_r) && (yj > py_r)) || ((yi_r > py_r) && (yj <= py_r));

  // Sign of px*dy-style cross product against dy decides left of the edge.
  assign diff     = {p1_r[P-1], p1_r} - {p2_r[P-1], p2_r};
  assign edge_hit = s2_vld_r && (diff != '0) && (diff[P] != s2_dyneg_r);

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      px_r <= coord_x;
      py_r <= coord_y;
    end
    if (s0_vld_r) begin
      xi_r <= xj;
      yi_r <= yj;
      if (s0_first_r) begin
        v0x_r <= xj;
        v0y_r <= yj;
      end
    end
    a_r        <= {px_r[W-1], px_r} - {xi_r[W-1], xi_r};
    c_r        <= {py_r[W-1], py_r} - {yi_r[W-1], yi_r};
    d_r        <= {xj[W-1], xj} - {xi_r[W-1], xi_r};
    dy_r       <= {yj[W-1], yj} - {yi_r[W-1], yi_r};
    p1_r       <= a_r * dy_r;
    p2_r       <= c_r * d_r;
    s2_dyneg_r <= dy_r[E-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r    <= 1'b0;
      s0_first_r  <= 1'b0;
      s0_close_r  <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_inside_r <= 1'b0;
      out_few_r   <= 1'b0;
    end else begin
      s0_vld_r   <= cmd.rd_en || cmd.close_edge;
      s0_first_r <= cmd.rd_first;
      s0_close_r <= cmd.close_edge;
      s1_vld_r   <= edge_vld && straddle;
      s2_vld_r   <= s1_vld_r;
      if (cmd.load_point) begin
        parity_r <= 1'b0;
      end else if (edge_hit) begin
        parity_r <= !parity_r;
      end
      if (cmd.load_result) begin
        out_valid_r  <= 1'b1;
        out_inside_r <= !cmd.too_few && parity_r;
        out_few_r    <= cmd.too_few;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.pipe_busy = s0_vld_r || s1_vld_r || s2_vld_r;
  assign status.out_busy  = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_inside = out_inside_r;
  assign out_few    = out_few_r;

endmodule
`default_nettype wire

FILE: sv/pip_checker.sv
// Port-level assertions for the point-in-polygon core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pip_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               in_tuser,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [pip_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input wire logic                               out_tuser
);
  import pip_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_few_is_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[0])
    else $error("too few vertices reported as inside");

  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_QUERY |=> !in_tready)
    else $error("input taken while a query is in progress");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_QUERY |=> !$rose(out_tvalid))
    else $error("result appeared one cycle after its query");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

FILE: bench/tb_point_in_polygon_test_core.sv
// Self-checking testbench for the point-in-polygon core: vertex loads, queries and count settings.
`timescale 1ns / 1ps

typedef struct packed {
  logic enclosed;
  logic few;
} pip_answer_t;

class containment_scoreboard;
  longint          vert_x[pip_pkg::MAX_VERTICES_DEF];
  longint          vert_y[pip_pkg::MAX_VERTICES_DEF];
  int unsigned     count_reg;
  pip_answer_t     pending_answers[$];
  int              errors;
  int              checked;
  int              enclosed_seen;
  int              few_seen;
  int              writes_seen;
  int              queries_seen;

  function new();
    foreach (vert_x[k]) begin
      vert_x[k] = 0;
      vert_y[k] = 0;
    end
    count_reg     = 0;
    errors        = 0;
    checked       = 0;
    enclosed_seen = 0;
    few_seen      = 0;
    writes_seen   = 0;
    queries_seen  = 0;
  endfunction

  function void set_count(int unsigned value);
    count_reg = value & 32'h7f;
  endfunction

  function int pending();
    return pending_answers.size();
  endfunction

  // Even-odd crossing count for a ray toward +x, with the crossing x compared
  // by cross-multiplying so that no division is needed.
  function pip_answer_t polygon_answer(longint px, longint py);
    pip_answer_t ans;
    int          n;
    int          i;
    int          j;
    bit          odd;
    longint      dy;
    longint      diff;
    ans.enclosed = 1'b0;
    ans.few      = 1'b0;
    odd          = 1'b0;
    n = (count_reg > pip_pkg::MAX_VERTICES_DEF) ? pip_pkg::MAX_VERTICES_DEF : count_reg;
    if (n < pip_pkg::MIN_VERTICES) begin
      ans.few = 1'b1;
      return ans;
    end
    for (i = 0; i < n; i++) begin
      j = (i == n - 1) ? 0 : i + 1;
      if ((vert_y[i] <= py) != (vert_y[j] <= py)) begin
        dy   = vert_y[j] - vert_y[i];
        diff = (px - vert_x[i]) * dy - (py - vert_y[i]) * (vert_x[j] - vert_x[i]);
        if (dy > 0 ? diff < 0 : diff > 0)
          odd = ~odd;
      end
    end
    ans.enclosed = odd;
    return ans;
  endfunction

  function void note_input(logic cmd, logic [5:0] idx, logic signed [15:0] x,
                           logic signed [15:0] y);
    if (cmd == pip_pkg::CMD_WRITE) begin
      vert_x[idx] = x;
      vert_y[idx] = y;
      writes_seen++;
    end else begin
      pending_answers.insert(pending_answers.size(), polygon_answer(x, y));
      queries_seen++;
    end
  endfunction

  function void check_result(logic enclosed, logic few);
    pip_answer_t want;
    if (pending_answers.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual inside_res=%b too_few=%b",
               $time, enclosed, few);
      return;
    end
    want = pending_answers.pop_front();
    checked++;
    if (want.enclosed)
      enclosed_seen++;
    if (want.few)
      few_seen++;
    if (enclosed !== want.enclosed) begin
      errors++;
      $display("%0t: inside_res mismatch: expected %b, actual %b", $time, want.enclosed, enclosed);
    end
    if (few !== want.few) begin
      errors++;
      $display("%0t: too_few_vertices mismatch: expected %b, actual %b", $time, want.few, few);
    end
  endfunction
endclass

module tb_point_in_polygon_test_core;
  localparam int IN_W         = ((pip_pkg::VIDX_W + 2 * 16 + 7) / 8) * 8;
  localparam int NV           = pip_pkg::MAX_VERTICES_DEF;
  localparam int ITEM_TARGET  = 1550;
  localparam int QUIET_CYCLES = NV + 16;
  localparam int LIMIT        = 1000000;
  localparam logic [pip_pkg::CFG_AW-1:0] VCOUNT_ADDR = {pip_pkg::CFG_VCOUNT_IDX, 2'b00};

  logic                          clk;
  logic                          rst_n;
  logic [IN_W-1:0]               in_tdata;
  logic                          in_tuser;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [pip_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                          out_tuser;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [pip_pkg::CFG_AW-1:0]    cfg_paddr;
  logic [pip_pkg::CFG_DW-1:0]    cfg_pwdata;
  logic [pip_pkg::CFG_DW-1:0]    cfg_prdata;
  logic                          cfg_pready;

  containment_scoreboard sb = new();

  int items_sent  = 0;
  int cycle_count = 0;
  int settings    = 0;
  int cur_count   = 0;
  bit slot_written[NV];
  int slot_x[NV];
  int slot_y[NV];

  point_in_polygon_test_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Idle schedule: receiver-heavy first, sender-heavy next, then none.
  function int idle_mode();
    if (items_sent < ITEM_TARGET / 3)
      return 0;
    else if (items_sent < 2 * ITEM_TARGET / 3)
      return 1;
    return 2;
  endfunction

  always @(negedge clk) begin
    case (idle_mode())
      0: out_tready = ($urandom_range(0, 99) >= 47);
      1: out_tready = ($urandom_range(0, 99) >= 26);
      default: out_tready = 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(in_tuser, in_tdata[5:0], in_tdata[21:6], in_tdata[37:22]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[0], out_tuser);
    end
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("point_in_polygon_test_core regression: fail");
    $finish;
  end

  function automatic int clamp16(int v);
    if (v > 32767)
      return 32767;
    if (v < -32768)
      return -32768;
    return v;
  endfunction

  function automatic int rand_near(int c, int span);
    return clamp16(c + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic int rand_full();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so the next call may follow back to back.
  task automatic send_item(logic cmd, int idx, int x, int y);
    logic [15:0] xs;
    logic [15:0] ys;
    logic [5:0]  is;
    int          idle_pct;
    xs = 16'(x);
    ys = 16'(y);
    is = 6'(idx);
    case (idle_mode())
      0: idle_pct = 26;
      1: idle_pct = 47;
      default: idle_pct = 0;
    endcase
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {2'b00, ys, xs, is};
    do
      @(posedge clk);
    while (!in_tready);
    @(negedge clk);
    items_sent++;
    if (cmd == pip_pkg::CMD_WRITE) begin
      slot_written[is] = 1'b1;
      slot_x[is] = x;
      slot_y[is] = y;
    end
  endtask

  task automatic write_vertex(int idx, int x, int y);
    send_item(pip_pkg::CMD_WRITE, idx, x, y);
  endtask

  task automatic query_point(int x, int y);
    send_item(pip_pkg::CMD_QUERY, $urandom_range(0, NV - 1), x, y);
  endtask

  // The count register may only change once the core is quiet again.
  task automatic set_vertex_count(int value);
    logic [pip_pkg::CFG_DW-1:0] readback;
    in_tvalid = 1'b0;
    while (sb.pending() != 0)
      @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = VCOUNT_ADDR;
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do
      @(posedge clk);
    while (!cfg_pready);
    sb.set_count(value);
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do
      @(posedge clk);
    while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    if (readback !== (value & 32'h7f)) begin
      sb.errors++;
      $display("%0t: vertex_count readback mismatch: expected %0d, actual %0d",
               $time, value & 32'h7f, readback);
    end
    cur_count = value;
    settings++;
  endtask

  task automatic directed_part();
    set_vertex_count(0);
    query_point(-32768, -32768);
    send_item(pip_pkg::CMD_QUERY, NV - 1, 32767, 32767);
    set_vertex_count(2);
    query_point(0, 0);
    // Square spanning the whole coordinate range.
    set_vertex_count(4);
    write_vertex(0, -32768, -32768);
    write_vertex(1, 32767, -32768);
    write_vertex(2, 32767, 32767);
    write_vertex(3, -32768, 32767);
    write_vertex(NV - 1, 32767, -32768);
    query_point(0, 0);
    query_point(-32768, 0);
    query_point(32767, 0);
    query_point(0, -32768);
    query_point(0, 32767);
    query_point(-32768, -32768);
    // Triangle: the point on the base and on a slanted edge test the half-open rule.
    set_vertex_count(3);
    write_vertex(0, 0, 0);
    write_vertex(1, 256, 512);
    write_vertex(2, 512, 0);
    query_point(256, 256);
    query_point(256, 0);
    query_point(128, 256);
  endtask

  task automatic random_phase();
    int r;
    int count;
    int n;
    int span;
    int cx;
    int cy;
    int k;
    int s;
    int t;
    int nq;
    bit descending;
    r = $urandom_range(0, 99);
    if (r < 8)
      count = $urandom_range(0, 2);
    else if (r < 60)
      count = $urandom_range(3, 8);
    else if (r < 85)
      count = $urandom_range(9, 24);
    else if (r < 93)
      count = $urandom_range(25, NV - 1);
    else if (r < 97)
      count = NV;
    else
      count = $urandom_range(NV + 1, 127);
    set_vertex_count(count);
    n = (count > NV) ? NV : count;

    r = $urandom_range(0, 99);
    if (r < 45)
      span = 256;
    else if (r < 80)
      span = 4096;
    else
      span = 32767;
    cx = int'($urandom_range(0, 65535 - 2 * span)) - 32768 + span;
    cy = int'($urandom_range(0, 65535 - 2 * span)) - 32768 + span;

    descending = 1'($urandom_range(0, 1));
    for (k = 0; k < n; k++) begin
      s = descending ? n - 1 - k : k;
      if (!slot_written[s] || $urandom_range(0, 7) != 0)
        write_vertex(s, rand_near(cx, span), rand_near(cy, span));
      if (n < NV && $urandom_range(0, 9) == 0)
        write_vertex($urandom_range(n, NV - 1), rand_full(), rand_full());
    end

    nq = (n < pip_pkg::MIN_VERTICES) ? $urandom_range(1, 4) : $urandom_range(2, 10);
    repeat (nq) begin
      if (n >= pip_pkg::MIN_VERTICES && $urandom_range(0, 9) == 0)
        write_vertex($urandom_range(0, n - 1), rand_near(cx, span), rand_near(cy, span));
      r = $urandom_range(0, 99);
      if (n < pip_pkg::MIN_VERTICES || r >= 85) begin
        if ($urandom_range(0, 3) == 0)
          query_point($urandom_range(0, 1) ? 32767 : -32768,
                      $urandom_range(0, 1) ? 32767 : -32768);
        else
          query_point(rand_full(), rand_full());
      end else begin
        s = $urandom_range(0, n - 1);
        t = (s == n - 1) ? 0 : s + 1;
        if (r < 40)
          query_point(rand_near(cx, span + span / 4), rand_near(cy, span + span / 4));
        else if (r < 55)
          query_point(slot_x[s], slot_y[s]);
        else if (r < 70)
          query_point(rand_near(cx, span), slot_y[s]);
        else if (r < 78)
          query_point(slot_x[s], rand_near(cy, span));
        else
          query_point((slot_x[s] + slot_x[t]) >>> 1, (slot_y[s] + slot_y[t]) >>> 1);
      end
    end
  endtask

  initial begin
    foreach (slot_written[k]) begin
      slot_written[k] = 1'b0;
      slot_x[k] = 0;
      slot_y[k] = 0;
    end
    rst_n       = 1'b0;
    in_tdata    = '0;
    in_tuser    = pip_pkg::CMD_WRITE;
    in_tvalid   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed_part();
    while (items_sent < ITEM_TARGET)
      random_phase();

    in_tvalid = 1'b0;
    while (sb.pending() != 0)
      @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);

    $display("Covered %0d vertex writes and %0d queries over %0d vertex_count settings.",
             sb.writes_seen, sb.queries_seen, settings);
    $display("Checked %0d results: %0d inside, %0d with too few vertices, %0d errors.",
             sb.checked, sb.enclosed_seen, sb.few_seen, sb.errors);
    if (sb.errors == 0)
      $display("point_in_polygon_test_core regression: pass");
    else
      $display("point_in_polygon_test_core regression: fail");
    $finish;
  end
endmodule

FILE: sim.f
sv/pip_pkg.sv
sv/pip_ctrl.sv
sv/pip_datapath.sv
sv/point_in_polygon_test_core.sv
sv/pip_checker.sv
bench/tb_point_in_polygon_test_core.sv
